// ----- rtl/eflx_pkg.sv -----
// Package for the Euler flux vector block: Q16.16 types, saturating
// arithmetic helpers, register and direction codes, divider constants.
// Depends on nothing.
package eflx_pkg;

  localparam int DATA_W   = 32;
  localparam int DSR_W    = 34;
  localparam int DIV_BITS = 2;
  localparam int DIV_ITER = DATA_W / DIV_BITS;
  localparam int DIV_LAT  = DIV_ITER + 3;
  localparam int ADDR_W   = 4;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef q_t q3_t [3];

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  // Register indexes
  localparam logic [1:0] REG_PRIM  = 2'd0;
  localparam logic [1:0] REG_GM1   = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;
  localparam logic [1:0] REG_BIAS  = 2'd3;

  localparam logic [17:0] GM1_RESET   = 18'd26214;
  localparam logic [16:0] FLOOR_RESET = 17'd1;
  localparam logic [16:0] BIAS_RESET  = 17'd0;

  // Flux directions
  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;
  localparam logic [1:0] DIR_Z = 2'd2;

  // One stage of the long division pipeline
  typedef struct packed {
    logic [DSR_W-1:0]  rem;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] quo;
    logic [DSR_W-1:0]  dsr;
    logic              ovf;
    logic              neg;
    logic              zero;
  } div_stage_t;

  function automatic q_t sat_q(input logic signed [65:0] x);
    q_t r;
    if (x > 66'(Q_MAX)) r = Q_MAX;
    else if (x < 66'(Q_MIN)) r = Q_MIN;
    else r = x[DATA_W-1:0];
    return r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] pr;
    pr = 64'(a) * 64'(b);
    return sat_q(66'(pr >>> 16));
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat_q(66'(a) + 66'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat_q(66'(a) - 66'(b));
  endfunction

endpackage

// ----- rtl/eflx_div.sv -----
// Pipelined signed Q16.16 divider, (a * 2^16) / d truncated toward zero,
// saturated, DIV_BITS quotient bits per stage. Depends on eflx_pkg.
module eflx_div import eflx_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  q_t                      dividend,
  input  logic signed [DSR_W-1:0] divisor,
  output q_t                      quotient
);

  logic [DATA_W-1:0] na;
  logic [DSR_W-1:0]  nd;
  logic              neg_a;
  logic              zero_a;
  div_stage_t        init;
  div_stage_t        it [DIV_ITER+1];
  div_stage_t        nxt [DIV_ITER];
  logic [DATA_W-1:0] q_fin;
  q_t                q_out;

  // One restoring division step
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t r;
    logic [DSR_W:0] r2;
    r  = s;
    r2 = {s.rem, s.low[DATA_W-1]};
    r.low = {s.low[DATA_W-2:0], 1'b0};
    if (r2 >= {1'b0, s.dsr}) begin
      r.rem = DSR_W'(r2 - {1'b0, s.dsr});
      r.quo = {s.quo[DATA_W-2:0], 1'b1};
    end else begin
      r.rem = r2[DSR_W-1:0];
      r.quo = {s.quo[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      na     <= dividend[DATA_W-1] ? ($unsigned(~dividend) + 1'b1) : $unsigned(dividend);
      nd     <= divisor[DSR_W-1] ? ($unsigned(~divisor) + 1'b1) : $unsigned(divisor);
      neg_a  <= dividend[DATA_W-1] ^ divisor[DSR_W-1];
      zero_a <= (dividend == '0);
    end
  end

  // Check for quotient overflow and seed the remainder
  always_comb begin
    init.ovf  = ({18'd0, na} >= {nd, 16'd0});
    init.rem  = {18'd0, na[31:16]};
    init.low  = {na[15:0], 16'd0};
    init.quo  = '0;
    init.dsr  = nd;
    init.neg  = neg_a;
    init.zero = zero_a;
  end

  // Produce DIV_BITS quotient bits per stage
  always_comb begin
    for (int i = 0; i < DIV_ITER; i++) begin
      nxt[i] = it[i];
      for (int b = 0; b < DIV_BITS; b++) begin
        nxt[i] = div_step(nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0] <= init;
      for (int i = 1; i <= DIV_ITER; i++) begin
        it[i] <= nxt[i-1];
      end
    end
  end

  // Apply sign and saturate
  assign q_fin = it[DIV_ITER].quo;
  always_comb begin
    if (it[DIV_ITER].zero) q_out = '0;
    else if (it[DIV_ITER].ovf) q_out = it[DIV_ITER].neg ? Q_MIN : Q_MAX;
    else if (it[DIV_ITER].neg) q_out = (q_fin > 32'h80000000) ? Q_MIN : q_t'(32'd0 - q_fin);
    else q_out = (q_fin[DATA_W-1]) ? Q_MAX : q_t'(q_fin);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= q_out;
    end
  end

endmodule

// ----- rtl/euler_flux_vector.sv -----
// Top level of the Euler flux vector block: config registers, arithmetic
// pipeline and result serializer. Depends on eflx_pkg and eflx_div.
//
// Usage: each item on the input channel (in_valid/in_ready) is one gas
// state in signed Q16.16, conserved or primitive as set by register REG_PRIM.
// For every item the output channel (out_valid/out_ready) gives three
// results, the x, y and z flux vectors in that order, with last set on z.
// Throughput is set by the single result channel that carries three
// results per item; the pipeline itself takes an item every cycle until
// the output buffer is full. The long depth comes from the four pipelined
// dividers (19 stages each, two quotient bits per iteration stage).
// Configuration is an APB-style port, registers at byte addresses 0, 4, 8
// and 12; write it only while the block is idle.
// Reset (rst, synchronous) empties the pipeline and the output buffer and
// restores register defaults. When the last stage is blocked, the whole
// pipeline holds in place and in_ready drops; nothing is lost or repeated.
module euler_flux_vector import eflx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  q_t                density,
  input  q_t                comp_x,
  input  q_t                comp_y,
  input  q_t                comp_z,
  input  q_t                energy_or_pressure,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        direction,
  output q_t                mass_flux,
  output q_t                flux_mom_x,
  output q_t                flux_mom_y,
  output q_t                flux_mom_z,
  output q_t                energy_flux,
  output logic              last
);

  logic        cfg_prim;
  logic [17:0] cfg_gm1;
  logic [16:0] cfg_floor;
  logic [16:0] cfg_bias;

  logic adv;
  logic load;

  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic vd [DIV_LAT];

  q_t  rho0, ep0;
  q3_t c0;
  q_t  rho1, ep1;
  q3_t c1, sq1;
  q_t  rho2, ep2, ss2;
  q3_t m2;
  q_t  rho3, ep3, kin3;
  q3_t m3;
  logic signed [DSR_W-1:0] dv3;
  q_t  rhod [DIV_LAT];
  q_t  kind [DIV_LAT];
  q_t  epd  [DIV_LAT];
  q_t  qp;
  q3_t qv;
  q_t  rho4, e4;
  q3_t vel4, sqv4;
  q_t  rho5, e5, sv5;
  q3_t vel5, mass5;
  q_t  e6, kv6;
  q3_t vel6, mass6;
  q_t  e7, t7;
  q3_t vel7, mass7;
  q_t  e8, p8;
  q3_t vel8, mass8;
  q_t  mom8 [3][3];
  q_t  pe9;
  q3_t vel9, mass9;
  q_t  f9 [3][3];

  logic       ob_valid;
  logic [1:0] cnt;
  q3_t        ob_mass, ob_ef;
  q_t         ob_mom [3][3];

  logic [32:0] mag1;

  // Configuration writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_prim  <= 1'b0;
      cfg_gm1   <= GM1_RESET;
      cfg_floor <= FLOOR_RESET;
      cfg_bias  <= BIAS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PRIM:  cfg_prim  <= pwdata[0];
        REG_GM1:   cfg_gm1   <= pwdata[17:0];
        REG_FLOOR: cfg_floor <= pwdata[16:0];
        REG_BIAS:  cfg_bias  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PRIM:  prdata = {31'd0, cfg_prim};
      REG_GM1:   prdata = {14'd0, cfg_gm1};
      REG_FLOOR: prdata = {15'd0, cfg_floor};
      REG_BIAS:  prdata = {15'd0, cfg_bias};
      default:   prdata = '0;
    endcase
  end

  // Advance the pipeline unless the last stage is blocked
  assign load     = v9 && (!ob_valid || (out_ready && cnt == DIR_Z));
  assign adv      = !v9 || load;
  assign in_ready = adv;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      for (int i = 0; i < DIV_LAT; i++) vd[i] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      vd[0] <= v3;
      for (int i = 1; i < DIV_LAT; i++) vd[i] <= vd[i-1];
      v4 <= vd[DIV_LAT-1];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  // Density magnitude for the floor check
  assign mag1 = rho0[DATA_W-1] ? (33'd0 - 33'(rho0)) : {1'b0, $unsigned(rho0)};

  // Front stages: floor, momenta, kinetic term, divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      rho0 <= density;
      c0   <= '{comp_x, comp_y, comp_z};
      ep0  <= energy_or_pressure;

      rho1 <= (cfg_prim && mag1 < {16'd0, cfg_floor}) ?
              q_t'(mag1[31:0] + {15'd0, cfg_floor}) : rho0;
      c1   <= c0;
      ep1  <= ep0;
      for (int k = 0; k < 3; k++) sq1[k] <= qmul(c0[k], c0[k]);

      rho2 <= rho1;
      ep2  <= ep1;
      ss2  <= qadd(qadd(sq1[0], sq1[1]), sq1[2]);
      for (int k = 0; k < 3; k++) m2[k] <= cfg_prim ? qmul(rho1, c1[k]) : c1[k];

      rho3 <= rho2;
      ep3  <= ep2;
      m3   <= m2;
      kin3 <= qmul(rho2, ss2) >>> 1;
      dv3  <= DSR_W'(rho2) + $signed({17'd0, cfg_bias});
    end
  end

  // Dividers: energy from pressure, and the three velocities
  eflx_div u_div_p (
    .clk      (clk),
    .en       (adv),
    .dividend (ep3),
    .divisor  ($signed({16'd0, cfg_gm1})),
    .quotient (qp)
  );

  for (genvar k = 0; k < 3; k++) begin : g_vel
    eflx_div u_div_v (
      .clk      (clk),
      .en       (adv),
      .dividend (m3[k]),
      .divisor  (dv3),
      .quotient (qv[k])
    );
  end

  // Carry side values alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      rhod[0] <= rho3;
      kind[0] <= kin3;
      epd[0]  <= ep3;
      for (int i = 1; i < DIV_LAT; i++) begin
        rhod[i] <= rhod[i-1];
        kind[i] <= kind[i-1];
        epd[i]  <= epd[i-1];
      end
    end
  end

  // Back stages: energy, pressure, fluxes
  always_ff @(posedge clk) begin
    if (adv) begin
      rho4 <= rhod[DIV_LAT-1];
      e4   <= cfg_prim ? qadd(qp, kind[DIV_LAT-1]) : epd[DIV_LAT-1];
      vel4 <= qv;
      for (int k = 0; k < 3; k++) sqv4[k] <= qmul(qv[k], qv[k]);

      rho5 <= rho4;
      e5   <= e4;
      vel5 <= vel4;
      sv5  <= qadd(qadd(sqv4[0], sqv4[1]), sqv4[2]);
      for (int n = 0; n < 3; n++) mass5[n] <= qmul(rho4, vel4[n]);

      e6    <= e5;
      vel6  <= vel5;
      mass6 <= mass5;
      kv6   <= qmul(rho5, sv5) >>> 1;

      e7    <= e6;
      vel7  <= vel6;
      mass7 <= mass6;
      t7    <= qsub(e6, kv6);

      e8    <= e7;
      vel8  <= vel7;
      mass8 <= mass7;
      p8    <= qmul($signed({14'd0, cfg_gm1}), t7);
      for (int n = 0; n < 3; n++) begin
        for (int k = 0; k < 3; k++) mom8[n][k] <= qmul(mass7[n], vel7[k]);
      end

      vel9  <= vel8;
      mass9 <= mass8;
      pe9   <= qadd(p8, e8);
      for (int n = 0; n < 3; n++) begin
        for (int k = 0; k < 3; k++) begin
          f9[n][k] <= (n == k) ? qadd(mom8[n][k], p8) : mom8[n][k];
        end
      end
    end
  end

  // Output buffer: hold one item and hand out its three results
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      cnt      <= DIR_X;
    end else if (load) begin
      ob_valid <= 1'b1;
      cnt      <= DIR_X;
    end else if (ob_valid && out_ready) begin
      if (cnt == DIR_Z) ob_valid <= 1'b0;
      else cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_mass <= mass9;
      ob_mom  <= f9;
      for (int n = 0; n < 3; n++) ob_ef[n] <= qmul(vel9[n], pe9);
    end
  end

  assign out_valid   = ob_valid;
  assign direction   = cnt;
  assign last        = (cnt == DIR_Z);
  assign mass_flux   = ob_mass[cnt];
  assign flux_mom_x  = ob_mom[cnt][0];
  assign flux_mom_y  = ob_mom[cnt][1];
  assign flux_mom_z  = ob_mom[cnt][2];
  assign energy_flux = ob_ef[cnt];

endmodule

// ----- sim/eflx_checker.sv -----
// Checker for the Euler flux vector block: watches both channels, predicts
// the three flux results of each accepted gas state and compares them.
// Depends on eflx_pkg.
module eflx_checker import eflx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  q_t          density,
  input  q_t          comp_x,
  input  q_t          comp_y,
  input  q_t          comp_z,
  input  q_t          energy_or_pressure,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  direction,
  input  q_t          mass_flux,
  input  q_t          flux_mom_x,
  input  q_t          flux_mom_y,
  input  q_t          flux_mom_z,
  input  q_t          energy_flux,
  input  logic        last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    logic [1:0] dir;
    longint     mass;
    longint     mom[3];
    longint     efx;
    logic       lst;
  } flux_t;

  flux_t flux_q[$];

  logic        cfg_prim;
  logic [17:0] cfg_gm1;
  logic [16:0] cfg_floor;
  logic [16:0] cfg_bias;

  assign pending_count = flux_q.size();

  function automatic longint clamp(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor division by a power of two (arithmetic shift floors)
  function automatic longint fx_mul(longint a, longint b);
    return clamp((a * b) >>> 16);
  endfunction

  function automatic longint fx_div(longint a, longint d);
    if (d == 0) return (a > 0) ? 64'sd2147483647 : (a < 0) ? -64'sd2147483648 : 0;
    return clamp((a * 65536) / d);
  endfunction

  function automatic longint half_kinetic(longint rho, longint v0, longint v1, longint v2);
    longint s;
    s = clamp(clamp(fx_mul(v0, v0) + fx_mul(v1, v1)) + fx_mul(v2, v2));
    return fx_mul(rho, s) >>> 1;
  endfunction

  // compute the x, y and z flux vectors of one gas state
  task automatic predict_fluxes(longint rho, longint m0, longint m1, longint m2,
                                longint e);
    longint mom[3], vel[3], gm1, p, pe, mag, dsr, mass, f;
    flux_t r;
    mom[0] = m0; mom[1] = m1; mom[2] = m2;
    gm1 = cfg_gm1;
    if (cfg_prim) begin
      mag = (rho < 0) ? -rho : rho;
      if (mag < cfg_floor) rho = mag + cfg_floor;
      for (int k = 0; k < 3; k++) vel[k] = mom[k];
      for (int k = 0; k < 3; k++) mom[k] = fx_mul(rho, vel[k]);
      e = clamp(fx_div(e, gm1) + half_kinetic(rho, vel[0], vel[1], vel[2]));
    end
    dsr = rho + cfg_bias;
    for (int k = 0; k < 3; k++) vel[k] = fx_div(mom[k], dsr);
    p = fx_mul(gm1, clamp(e - half_kinetic(rho, vel[0], vel[1], vel[2])));
    pe = clamp(p + e);
    for (int n = 0; n < 3; n++) begin
      mass = fx_mul(rho, vel[n]);
      r.dir = n[1:0];
      r.mass = mass;
      for (int k = 0; k < 3; k++) begin
        f = fx_mul(mass, vel[k]);
        if (k == n) f = clamp(f + p);
        r.mom[k] = f;
      end
      r.efx = fx_mul(vel[n], pe);
      r.lst = (n == 2);
      flux_q.push_back(r);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    flux_t x;
    if (rst) begin
      cfg_prim  <= 1'b0;
      cfg_gm1   <= GM1_RESET;
      cfg_floor <= FLOOR_RESET;
      cfg_bias  <= BIAS_RESET;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PRIM:  cfg_prim  <= pwdata[0];
          REG_GM1:   cfg_gm1   <= pwdata[17:0];
          REG_FLOOR: cfg_floor <= pwdata[16:0];
          REG_BIAS:  cfg_bias  <= pwdata[16:0];
          default: ;
        endcase
      end
      // compare each result item with the oldest prediction
      if (out_valid && out_ready) begin
        if (flux_q.size() == 0) begin
          $error("unexpected result item, direction %0d", direction);
          fail_count++;
        end else begin
          x = flux_q.pop_front();
          check_field("direction", x.dir, direction);
          check_field("mass_flux", x.mass, mass_flux);
          check_field("flux_mom_x", x.mom[0], flux_mom_x);
          check_field("flux_mom_y", x.mom[1], flux_mom_y);
          check_field("flux_mom_z", x.mom[2], flux_mom_z);
          check_field("energy_flux", x.efx, energy_flux);
          check_field("last", x.lst, last);
        end
      end
      // predict from each accepted gas state
      if (in_valid && in_ready)
        predict_fluxes(density, comp_x, comp_y, comp_z, energy_or_pressure);
    end
  end

  initial fail_count = 0;

endmodule

// ----- sim/tb_euler_flux_vector.sv -----
// Testbench top for the Euler flux vector block: clock, reset, register
// writes, gas state stimulus and verdict. Depends on eflx_pkg, the block
// and eflx_checker.
module tb_euler_flux_vector;
  import eflx_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  q_t density = '0, comp_x = '0, comp_y = '0, comp_z = '0, energy_or_pressure = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] direction;
  q_t mass_flux, flux_mom_x, flux_mom_y, flux_mom_z, energy_flux;
  logic last;
  int fail_count, pending_count;

  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  always #5 clk = ~clk;

  euler_flux_vector dut (.*);

  eflx_checker chk (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain all expected results, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // offer one gas state and hold it until accepted
  task automatic send_state(q_t d, q_t x, q_t y, q_t z, q_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    density <= d; comp_x <= x; comp_y <= y; comp_z <= z; energy_or_pressure <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random field: full range, small values, or extremes
  function automatic q_t rand_q();
    case ($urandom_range(5))
      0: return q_t'($urandom);
      1: return Q_MAX;
      2: return Q_MIN;
      3: return q_t'(0);
      default: return q_t'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  function automatic q_t rand_rho();
    if ($urandom_range(3) == 0) return rand_q();
    return q_t'($urandom_range(655360, 1));
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_state(rand_rho(), rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, conserved mode
    send_state(32'sh00010000, 32'sh00020000, 32'shffff0000, 0, 32'sh00050000);
    send_state(0, 32'sh00010000, -32'sh00010000, 0, 32'sh00010000);
    send_state(0, 0, 0, 0, 0);
    send_state(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    send_state(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
    send_state(32'shffffffff, 32'sh7fff0000, 1, -1, 32'sh00100000);
    send_state(-32'sh00010000, 32'sh00030000, 32'sh00030000, 32'sh00030000, -5);
    drain();

    // directed: primitive mode, density floor, zero gamma
    reg_write(REG_PRIM, 32'd1);
    reg_write(REG_FLOOR, 32'd65536);
    send_state(32'sh00008000, 32'sh00010000, 32'sh00020000, -32'sh00010000, 32'sh00010000);
    send_state(-32'sh00008000, 0, 0, 0, 32'sh00010000);
    send_state(0, Q_MAX, Q_MIN, 1, Q_MAX);
    send_state(Q_MIN, 32'sh00010000, 0, 0, Q_MIN);
    drain();
    reg_write(REG_GM1, 32'd0);
    reg_write(REG_BIAS, 32'd65536);
    send_state(32'sh00020000, 32'sh00010000, 0, 0, 32'sh00010000);
    send_state(32'sh00020000, 0, 0, 0, -32'sh00010000);
    send_state(32'sh00020000, 0, 0, 0, 0);
    drain();
    reg_write(REG_GM1, 32'h3ffff);
    reg_write(REG_FLOOR, 32'h1ffff);
    reg_write(REG_BIAS, 32'h1ffff);
    send_state(-32'sh00020000, 32'sh00010000, -1, Q_MAX, 32'sh00030000);
    send_state(32'sh00010000, Q_MIN, Q_MAX, 0, Q_MAX);
    drain();
    reg_write(REG_BIAS, 32'hffffffff);
    reg_write(REG_GM1, 32'd131072);
    reg_write(REG_PRIM, 32'd0);
    send_state(-32'sh0001ffff, 32'sh00010000, 0, 0, 32'sh00010000);
    send_state(32'sh00010000, -32'sh00010000, 32'sh00020000, 1, 32'sh00040000);
    drain();

    // random phases across settings and idling profiles
    send_idle_pct = 17; recv_idle_pct = 45;
    reg_write(REG_PRIM, 32'd0); reg_write(REG_GM1, 32'd26214);
    reg_write(REG_FLOOR, 32'd1); reg_write(REG_BIAS, 32'd0);
    send_random(120);
    drain();

    send_idle_pct = 45; recv_idle_pct = 17;
    reg_write(REG_PRIM, 32'd1); reg_write(REG_GM1, $urandom_range(131072));
    reg_write(REG_FLOOR, $urandom_range(65536));
    send_random(120);
    drain();

    // long receiver hold-off so the pipeline fills and stalls its input
    send_idle_pct = 0; recv_idle_pct = 0;
    reg_write(REG_BIAS, $urandom_range(65536));
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
      end
      send_random(60);
    join
    drain();

    reg_write(REG_PRIM, 32'd0); reg_write(REG_GM1, $urandom_range(131072));
    reg_write(REG_BIAS, $urandom_range(65536));
    send_random(150);
    drain();

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
